FILE: sv/rac_pkg.sv
// rac_pkg: shared types and constants for the region average colour block
// holds request widths, conversion coefficients, register indexes and the
// command/status structs between controller and datapath; no dependencies
`default_nettype none

package rac_pkg;

    // request payload widths
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned PIX_W  = 3 * CHAN_W;
    localparam int unsigned CFG_W  = 13;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned IVL_W  = 8;
    localparam int unsigned Q_W    = 8;
    localparam int unsigned STEP_W = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH     = 13'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT    = 13'd480;
    localparam logic [IVL_W-1:0] RST_SAMPLE_INTERVAL = 8'd4;

    // conversion accumulator, 10 fractional bits
    localparam int unsigned ACC_W = 22;
    typedef logic signed [ACC_W-1:0] acc_t;

    localparam acc_t K_Y  = 22'sd1192;
    localparam acc_t K_RV = 22'sd1634;
    localparam acc_t K_GV = 22'sd833;
    localparam acc_t K_GU = 22'sd400;
    localparam acc_t K_BU = 22'sd2066;
    localparam acc_t OFS_Y = 22'sd16;
    localparam acc_t OFS_C = 22'sd128;

    typedef struct packed {
        logic in_ready;
        logic div_load;
        logic div_step;
        logic out_load;
    } rac_cmd_t;

    typedef struct packed {
        logic s1_sampled_end;
        logic next_sampled_end;
        logic out_valid;
    } rac_status_t;

endpackage

`default_nettype wire

FILE: sv/rac_divider.sv
// rac_divider: three-lane restoring divider, one quotient bit per step
// quotient is known to fit eight bits; a zero count gives zero; uses rac_pkg
`default_nettype none

module rac_divider #(
    parameter int unsigned CNT_W = 22
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire logic                      step,
    input  wire logic [CNT_W+7:0]          red_sum,
    input  wire logic [CNT_W+7:0]          green_sum,
    input  wire logic [CNT_W+7:0]          blue_sum,
    input  wire logic [CNT_W-1:0]          count,
    output logic      [rac_pkg::Q_W-1:0]   q_red,
    output logic      [rac_pkg::Q_W-1:0]   q_green,
    output logic      [rac_pkg::Q_W-1:0]   q_blue
);

    localparam int unsigned TW = CNT_W + 8;
    localparam int unsigned DW = CNT_W + rac_pkg::Q_W - 1;

    logic [TW-1:0]             rem_r_reg, rem_g_reg, rem_b_reg;
    logic [DW-1:0]             dsh_reg;
    logic [rac_pkg::Q_W-1:0]   quo_r_reg, quo_g_reg, quo_b_reg;
    logic                      zero_reg;

    logic ge_r, ge_g, ge_b;

    assign ge_r = rem_r_reg >= TW'(dsh_reg);
    assign ge_g = rem_g_reg >= TW'(dsh_reg);
    assign ge_b = rem_b_reg >= TW'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= 1'b1;
        end
        else if (load)
        begin
            zero_reg <= (count == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_r_reg <= red_sum;
            rem_g_reg <= green_sum;
            rem_b_reg <= blue_sum;
            dsh_reg   <= {count, {(rac_pkg::Q_W-1){1'b0}}};
            quo_r_reg <= '0;
            quo_g_reg <= '0;
            quo_b_reg <= '0;
        end
        else if (step)
        begin
            if (ge_r)
            begin
                rem_r_reg <= rem_r_reg - TW'(dsh_reg);
            end
            if (ge_g)
            begin
                rem_g_reg <= rem_g_reg - TW'(dsh_reg);
            end
            if (ge_b)
            begin
                rem_b_reg <= rem_b_reg - TW'(dsh_reg);
            end
            quo_r_reg <= {quo_r_reg[rac_pkg::Q_W-2:0], ge_r};
            quo_g_reg <= {quo_g_reg[rac_pkg::Q_W-2:0], ge_g};
            quo_b_reg <= {quo_b_reg[rac_pkg::Q_W-2:0], ge_b};
            dsh_reg   <= dsh_reg >> 1;
        end
    end

    assign q_red   = zero_reg ? '0 : quo_r_reg;
    assign q_green = zero_reg ? '0 : quo_g_reg;
    assign q_blue  = zero_reg ? '0 : quo_b_reg;

endmodule

`default_nettype wire

FILE: sv/rac_datapath.sv
// rac_datapath: registers, position counters, colour conversion, sums,
// divider and output register; driven by rac_control, uses rac_pkg and rac_divider
`default_nettype none

module rac_datapath #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned MAX_HEIGHT     = 4096,
    parameter int unsigned REGION_DIVISOR = 8,
    parameter int unsigned CNT_W          = 22
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rac_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [rac_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    input  wire logic [rac_pkg::PIX_W-1:0]     in_data,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic      [rac_pkg::PIX_W-1:0]     out_data,
    input  wire rac_pkg::rac_cmd_t             cmd,
    output rac_pkg::rac_status_t               st
);

    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned TW = CNT_W + 8;
    localparam int unsigned PW = WW + 7;

    localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14 = 14'(MAX_HEIGHT);

    // configuration
    logic [rac_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [rac_pkg::IVL_W-1:0] sample_interval_reg;

    // position
    logic [CW-1:0]             col_reg;
    logic [RW-1:0]             row_reg;
    logic [rac_pkg::IVL_W-1:0] phase_reg;

    // conversion stage
    logic                      s1_add_reg, s1_end_reg, s1_send_reg;
    rac_pkg::acc_t             s1_red_reg, s1_green_reg, s1_blue_reg;

    // sums
    logic [TW-1:0]             red_total_reg, green_total_reg, blue_total_reg;
    logic [CNT_W-1:0]          count_reg;

    // result
    logic                      out_valid_reg;
    logic [rac_pkg::PIX_W-1:0] out_data_reg;

    logic [13:0]               fw_ext, fh_ext;
    logic [WW-1:0]             w_lim, col_inc;
    logic [HW-1:0]             h_lim, row_inc;
    logic [rac_pkg::IVL_W-1:0] ivl;
    logic [rac_pkg::IVL_W:0]   phase_inc;
    logic [rac_pkg::IVL_W-1:0] phase_next;
    logic                      row_end, frame_end, sampled, in_region, accept;
    rac_pkg::acc_t             y_s, u_s, v_s;
    logic [rac_pkg::CHAN_W-1:0] ch_red, ch_green, ch_blue;
    logic [TW-1:0]             red_sum, green_sum, blue_sum;
    logic [CNT_W-1:0]          count_sum;
    logic [rac_pkg::Q_W-1:0]   q_red, q_green, q_blue;

    function automatic logic [rac_pkg::CHAN_W-1:0] to_channel(input rac_pkg::acc_t acc);
        logic [rac_pkg::ACC_W-11:0] q;
        begin
            q = acc[rac_pkg::ACC_W-1:10];
            if (acc < 0)
            begin
                to_channel = '0;
            end
            else if (q > (rac_pkg::ACC_W-10)'(255))
            begin
                to_channel = 8'hFF;
            end
            else
            begin
                to_channel = q[rac_pkg::CHAN_W-1:0];
            end
        end
    endfunction

    // frame size limits: zero counts as one, large values saturate
    assign fw_ext = {1'b0, frame_width_reg};
    assign fh_ext = {1'b0, frame_height_reg};

    always_comb
    begin
        if (fw_ext == '0)
        begin
            w_lim = WW'(1);
        end
        else if (fw_ext > MAX_W14)
        begin
            w_lim = WW'(MAX_W14);
        end
        else
        begin
            w_lim = WW'(fw_ext);
        end

        if (fh_ext == '0)
        begin
            h_lim = HW'(1);
        end
        else if (fh_ext > MAX_H14)
        begin
            h_lim = HW'(MAX_H14);
        end
        else
        begin
            h_lim = HW'(fh_ext);
        end
    end

    assign ivl       = (sample_interval_reg == '0) ? rac_pkg::IVL_W'(1) : sample_interval_reg;
    assign col_inc   = WW'(col_reg) + WW'(1);
    assign row_inc   = HW'(row_reg) + HW'(1);
    assign row_end   = col_inc >= w_lim;
    assign frame_end = row_end && (row_inc >= h_lim);
    assign sampled   = (phase_reg == '0);
    // column < width / divisor, written without a divide
    assign in_region = (PW'(col_inc) * PW'(REGION_DIVISOR)) <= PW'(w_lim);
    assign phase_inc = {1'b0, phase_reg} + (rac_pkg::IVL_W+1)'(1);
    assign phase_next = (phase_inc >= {1'b0, ivl}) ? '0 : phase_inc[rac_pkg::IVL_W-1:0];
    assign accept    = in_valid && cmd.in_ready;

    assign y_s = rac_pkg::acc_t'($signed({1'b0, in_data[7:0]})) - rac_pkg::OFS_Y;
    assign u_s = rac_pkg::acc_t'($signed({1'b0, in_data[15:8]})) - rac_pkg::OFS_C;
    assign v_s = rac_pkg::acc_t'($signed({1'b0, in_data[23:16]})) - rac_pkg::OFS_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= rac_pkg::RST_FRAME_WIDTH;
            frame_height_reg    <= rac_pkg::RST_FRAME_HEIGHT;
            sample_interval_reg <= rac_pkg::RST_SAMPLE_INTERVAL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rac_pkg::REG_FRAME_WIDTH:     frame_width_reg     <= cfg_wdata;
                rac_pkg::REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_wdata;
                rac_pkg::REG_SAMPLE_INTERVAL:
                    sample_interval_reg <= cfg_wdata[rac_pkg::IVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= '0;
            s1_add_reg  <= 1'b0;
            s1_end_reg  <= 1'b0;
            s1_send_reg <= 1'b0;
        end
        else
        begin
            s1_add_reg  <= accept && sampled && in_region;
            s1_end_reg  <= accept && frame_end;
            s1_send_reg <= accept && frame_end && sampled;
            if (accept)
            begin
                if (row_end)
                begin
                    col_reg <= '0;
                    if (frame_end)
                    begin
                        row_reg   <= '0;
                        phase_reg <= phase_next;
                    end
                    else
                    begin
                        row_reg <= row_inc[RW-1:0];
                    end
                end
                else
                begin
                    col_reg <= col_inc[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg   <= rac_pkg::K_Y * y_s + rac_pkg::K_RV * v_s;
            s1_green_reg <= rac_pkg::K_Y * y_s - rac_pkg::K_GV * v_s - rac_pkg::K_GU * u_s;
            s1_blue_reg  <= rac_pkg::K_Y * y_s + rac_pkg::K_BU * u_s;
        end
    end

    // clamp and accumulate
    assign ch_red   = to_channel(s1_red_reg);
    assign ch_green = to_channel(s1_green_reg);
    assign ch_blue  = to_channel(s1_blue_reg);

    assign red_sum   = red_total_reg   + (s1_add_reg ? TW'(ch_red)   : '0);
    assign green_sum = green_total_reg + (s1_add_reg ? TW'(ch_green) : '0);
    assign blue_sum  = blue_total_reg  + (s1_add_reg ? TW'(ch_blue)  : '0);
    assign count_sum = count_reg + (s1_add_reg ? CNT_W'(1) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
            count_reg       <= '0;
        end
        else if (s1_end_reg)
        begin
            red_total_reg   <= '0;
            green_total_reg <= '0;
            blue_total_reg  <= '0;
            count_reg       <= '0;
        end
        else if (s1_add_reg)
        begin
            red_total_reg   <= red_sum;
            green_total_reg <= green_sum;
            blue_total_reg  <= blue_sum;
            count_reg       <= count_sum;
        end
    end

    rac_divider #(
        .CNT_W (CNT_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .step      (cmd.div_step),
        .red_sum   (red_sum),
        .green_sum (green_sum),
        .blue_sum  (blue_sum),
        .count     (count_sum),
        .q_red     (q_red),
        .q_green   (q_green),
        .q_blue    (q_blue)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {q_blue, q_green, q_red};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign st.s1_sampled_end   = s1_send_reg;
    assign st.next_sampled_end = frame_end && sampled;
    assign st.out_valid        = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/rac_control.sv
// rac_control: state machine that runs the end-of-frame division and
// gates input requests; commands rac_datapath through rac_pkg structs
`default_nettype none

module rac_control (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rac_pkg::rac_status_t st,
    output rac_pkg::rac_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [rac_pkg::STEP_W-1:0]  step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        // the last pixel of a sampled frame waits until divider and output are free
        cmd.in_ready = !(st.next_sampled_end &&
                         ((state_reg != ST_IDLE) || st.s1_sampled_end || st.out_valid));
        cmd.div_load = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (st.s1_sampled_end)
                begin
                    cmd.div_load = 1'b1;
                    step_next    = '1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    step_next = step_reg - rac_pkg::STEP_W'(1);
                end
            end
            ST_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/region_average_color.sv
// region_average_color: one pixel request per clock unless held off; the frame's result
// leaves the output register after its last pixel passes the conversion stage, the
// divider snapshot, 8 divider steps and the output load
// the last pixel of a sampled frame is held off while a division runs or a result waits
// reset: positions, frame phase and sums clear; width 640, height 480, interval 4
// depends on rac_pkg, rac_datapath, rac_control
`default_nettype none

module region_average_color #(
    parameter int unsigned MAX_WIDTH      = 4096,
    parameter int unsigned MAX_HEIGHT     = 4096,
    parameter int unsigned REGION_DIVISOR = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [rac_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [rac_pkg::CFG_W-1:0]    cfg_wdata,
    // pixel requests in
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [rac_pkg::PIX_W-1:0]    s_axis_tdata,  // luma, chroma_blue, chroma_red
    // averaged colour out
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic      [rac_pkg::PIX_W-1:0]    m_axis_tdata   // avg_red, avg_green, avg_blue
);

    // sum counter covers every summed pixel of the largest frame
    localparam int unsigned REGION_MAX = (MAX_WIDTH / REGION_DIVISOR) * MAX_HEIGHT;
    localparam int unsigned CNT_W      = (REGION_MAX > 0) ? $clog2(REGION_MAX + 1) : 1;

    rac_pkg::rac_cmd_t    cmd;
    rac_pkg::rac_status_t st;

    // position tracking, conversion, sums, divider and output register
    rac_datapath #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .REGION_DIVISOR (REGION_DIVISOR),
        .CNT_W          (CNT_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .st        (st)
    );

    // sequences the division and holds off the input when needed
    rac_control u_control (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    assign s_axis_tready = cmd.in_ready;

    // a sampled frame's last pixel is only taken with the output register empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && st.next_sampled_end) |-> !m_axis_tvalid)
        else $error("frame end taken while a result is pending");

    // a new result never overwrites one that waits
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !m_axis_tvalid)
        else $error("result overwritten");

    // loading the output register raises valid
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("result lost after load");

    // division only starts from a sampled frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> st.s1_sampled_end)
        else $error("division started without frame end");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for region_average_color, pixel stream in, colour means out
// predicts each sampled frame's left-region mean, checks every result in order
// depends on rac_pkg and the region_average_color rtl
`timescale 1ns / 100ps

module tb_top;

    // block parameters, kept at the rtl defaults
    localparam int unsigned MAX_W      = 4096;
    localparam int unsigned MAX_H      = 4096;
    localparam int unsigned REGION_DIV = 8;

    // bt.601 coefficients with 10 fractional bits
    localparam int COEF_Y  = 1192;
    localparam int COEF_RV = 1634;
    localparam int COEF_GV = 833;
    localparam int COEF_GU = 400;
    localparam int COEF_BU = 2066;

    // run shaping
    localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int unsigned SETTLE_CYCLES = 16;    // covers the end-of-frame division and output load
    localparam int unsigned RANDOM_PIXELS = 1250;
    localparam int unsigned WIDE_PIXELS   = 600;   // past the 512 summed columns of a wide row

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } pacing_e;

    // result layout, avg_red in the lowest byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_mean_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                        cfg_wr_en = 1'b0;
    logic [rac_pkg::IDX_W-1:0]   cfg_index = rac_pkg::REG_FRAME_WIDTH;
    logic [rac_pkg::CFG_W-1:0]   cfg_wdata = '0;

    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [rac_pkg::PIX_W-1:0]   s_axis_tdata  = '0;   // luma, chroma_blue, chroma_red
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [rac_pkg::PIX_W-1:0]   m_axis_tdata;         // avg_red, avg_green, avg_blue

    // stimulus and expectation stores
    logic [rac_pkg::PIX_W-1:0]   pixel_queue[$];
    rgb_mean_t                   expected_means[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;

    // predictor copy of the registers
    int unsigned cfg_width    = 640;
    int unsigned cfg_height   = 480;
    int unsigned cfg_interval = 4;

    // predictor copy of the frame state
    int unsigned col_pos      = 0;
    int unsigned row_pos      = 0;
    int unsigned frame_phase  = 0;
    int unsigned red_sum      = 0;
    int unsigned green_sum    = 0;
    int unsigned blue_sum     = 0;
    int unsigned summed_count = 0;

    region_average_color #(
        .MAX_WIDTH      (MAX_W),
        .MAX_HEIGHT     (MAX_H),
        .REGION_DIVISOR (REGION_DIV)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // zero dimension counts as one, oversize saturates
    function automatic int unsigned eff_dim(input int unsigned value, input int unsigned maxv);
        if (value == 0)
            return 1;
        return (value > maxv) ? maxv : value;
    endfunction

    // floor of the fixed-point sum, clamped to a byte
    function automatic logic [7:0] clamp_channel(input int acc);
        if (acc < 0)
            return 8'd0;
        if (acc / 1024 > 255)
            return 8'd255;
        return 8'(acc / 1024);
    endfunction

    function automatic logic [7:0] region_mean(input int unsigned total, input int unsigned count);
        if (count == 0)
            return 8'd0;
        return 8'(total / count);
    endfunction

    // advance the frame state by one accepted pixel, queue a mean at a sampled frame end
    function automatic void account_pixel(input logic [rac_pkg::PIX_W-1:0] pix);
        int          y;
        int          u;
        int          v;
        int unsigned w;
        int unsigned h;
        int unsigned ivl;
        bit          sampled;
        rgb_mean_t   mean;
        w       = eff_dim(cfg_width, MAX_W);
        h       = eff_dim(cfg_height, MAX_H);
        ivl     = (cfg_interval == 0) ? 1 : cfg_interval;
        sampled = (frame_phase == 0);
        y = int'(pix[7:0]) - 16;
        u = int'(pix[15:8]) - 128;
        v = int'(pix[23:16]) - 128;

        // only the left eighth of each row of a sampled frame is summed
        if (sampled && col_pos < w / REGION_DIV)
        begin
            red_sum   += clamp_channel(COEF_Y * y + COEF_RV * v);
            green_sum += clamp_channel(COEF_Y * y - COEF_GV * v - COEF_GU * u);
            blue_sum  += clamp_channel(COEF_Y * y + COEF_BU * u);
            summed_count++;
        end

        // a position already past a freshly shrunk limit ends the row or frame here
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            if (row_pos + 1 >= h)
            begin
                row_pos = 0;
                if (sampled)
                begin
                    mean.red   = region_mean(red_sum, summed_count);
                    mean.green = region_mean(green_sum, summed_count);
                    mean.blue  = region_mean(blue_sum, summed_count);
                    expected_means.push_back(mean);
                end
                red_sum      = 0;
                green_sum    = 0;
                blue_sum     = 0;
                summed_count = 0;
                frame_phase  = (frame_phase + 1 >= ivl) ? 0 : frame_phase + 1;
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
    endfunction

    function automatic void check_channel(input string label, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // channel values lean towards the rails so the clamps get exercised
    function automatic logic [rac_pkg::PIX_W-1:0] random_pixel();
        logic [rac_pkg::PIX_W-1:0] pix;
        pix = rac_pkg::PIX_W'($urandom);
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(7))
                0: pix[k*8 +: 8] = 8'h00;
                1: pix[k*8 +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return pix;
    endfunction

    function automatic void set_pacing(input pacing_e mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endfunction

    // register write, mirrored into the predictor at the edge that takes it
    task automatic write_register(input logic [rac_pkg::IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[rac_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rac_pkg::REG_FRAME_WIDTH:     cfg_width    = value & 32'h1FFF;
            rac_pkg::REG_FRAME_HEIGHT:    cfg_height   = value & 32'h1FFF;
            rac_pkg::REG_SAMPLE_INTERVAL: cfg_interval = value & 32'hFF;
            default: ;
        endcase
    endtask

    // block idle: every pixel taken, every mean back, then the tail of any division
    task automatic wait_quiet();
        @(negedge clk);
        while (pixel_queue.size() != 0 || s_axis_tvalid || expected_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void queue_random_pixels(input int unsigned count);
        repeat (count) pixel_queue.push_back(random_pixel());
    endfunction

    // pixel driver, a request stays up until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on every accepted pixel, check every accepted mean
    always @(posedge clk)
    begin : monitor
        rgb_mean_t want;
        rgb_mean_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                account_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_means.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
                    mismatches++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    check_channel("avg_red", want.red, got.red);
                    check_channel("avg_green", want.green, got.green);
                    check_channel("avg_blue", want.blue, got.blue);
                end
            end
        end
    end

    // watchdog on stretches with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // column 0 of each row is summed at width 8, so black/white and the rails land there;
    // the other columns carry colour extremes that only move the position
    localparam logic [rac_pkg::PIX_W-1:0] DIRECTED_PIXELS [16] = '{
        24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00,
        24'h808010, 24'h8080EB, 24'hFF0000, 24'h00FFFF,
        24'hFFFFFF, 24'h000000, 24'h0000FF, 24'hFFFF00,
        24'h80FF80, 24'hFF8080, 24'h008080, 24'h80007F
    };

    initial
    begin
        int unsigned random_queued;
        int unsigned phase_no;
        int unsigned frame_px;
        int unsigned burst;
        random_queued = 0;
        phase_no      = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one 8x2 frame, every frame sampled
        set_pacing(IDLE_NONE);
        write_register(rac_pkg::REG_FRAME_WIDTH, 8);
        write_register(rac_pkg::REG_FRAME_HEIGHT, 2);
        write_register(rac_pkg::REG_SAMPLE_INTERVAL, 1);
        foreach (DIRECTED_PIXELS[i])
            pixel_queue.push_back(DIRECTED_PIXELS[i]);
        wait_quiet();

        // empty region, width below the divisor gives an all-zero mean
        write_register(rac_pkg::REG_FRAME_WIDTH, 4);
        queue_random_pixels(8);
        wait_quiet();

        // zero width and height act as one, every pixel closes a frame
        write_register(rac_pkg::REG_FRAME_WIDTH, 0);
        write_register(rac_pkg::REG_FRAME_HEIGHT, 0);
        queue_random_pixels(3);
        wait_quiet();

        // random phases; the sender always waits for the block to drain between them,
        // and a phase may stop mid-frame so the next writes land with the position part-way
        while (random_queued < RANDOM_PIXELS)
        begin
            set_pacing(pacing_e'(phase_no % 4));
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(9))
                    0:       write_register(rac_pkg::REG_FRAME_WIDTH, 0);
                    1:       write_register(rac_pkg::REG_FRAME_WIDTH, $urandom_range(1, 7));
                    default: write_register(rac_pkg::REG_FRAME_WIDTH, $urandom_range(8, 24));
                endcase
            end
            if ($urandom_range(3) != 0)
            begin
                if ($urandom_range(9) == 0)
                    write_register(rac_pkg::REG_FRAME_HEIGHT, 0);
                else
                    write_register(rac_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 3));
            end
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(19))
                    0:          write_register(rac_pkg::REG_SAMPLE_INTERVAL, 0);
                    1:          write_register(rac_pkg::REG_SAMPLE_INTERVAL, 255);
                    2, 3, 4, 5: write_register(rac_pkg::REG_SAMPLE_INTERVAL, $urandom_range(2, 5));
                    default:    write_register(rac_pkg::REG_SAMPLE_INTERVAL, 1);
                endcase
            end
            frame_px = eff_dim(cfg_width, MAX_W) * eff_dim(cfg_height, MAX_H);
            burst    = frame_px * $urandom_range(1, 3) + $urandom_range(0, frame_px - 1);
            queue_random_pixels(burst);
            random_queued += burst;
            wait_quiet();
            phase_no++;
        end

        // bring position and frame phase back to the start of a sampled frame
        set_pacing(IDLE_NONE);
        write_register(rac_pkg::REG_FRAME_WIDTH, 1);
        write_register(rac_pkg::REG_FRAME_HEIGHT, 1);
        write_register(rac_pkg::REG_SAMPLE_INTERVAL, 1);
        queue_random_pixels(1);
        wait_quiet();

        // oversize width saturates, so only the first 512 columns of the row are summed;
        // shrinking the width part-way then closes the single-row frame
        write_register(rac_pkg::REG_FRAME_WIDTH, 8191);
        queue_random_pixels(WIDE_PIXELS);
        wait_quiet();
        write_register(rac_pkg::REG_FRAME_WIDTH, 8);
        queue_random_pixels(1);
        wait_quiet();

        if (mismatches == 0 && expected_means.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
